// File: hw/rtl/swc_pkg.sv
// swc_pkg: shared types and constants of the settable wall clock
// no dependencies; imported by every module of the block
package swc_pkg;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_RESET,
    OP_SET,
    OP_STOP
  } op_e;

  typedef struct packed {
    logic [1:0] hour_tens;
    logic [3:0] hour_ones;
    logic [2:0] minute_tens;
    logic [3:0] minute_ones;
    logic [2:0] second_tens;
    logic [3:0] second_ones;
  } time_t;

  typedef struct packed {
    op_e   op;
    time_t load;
  } cmd_t;

  localparam logic [7:0] CharW     = 8'h57;
  localparam logic [7:0] CharR     = 8'h52;
  localparam logic [7:0] CharS     = 8'h53;
  localparam logic [7:0] CharT     = 8'h54;
  localparam logic [7:0] CharColon = 8'h3a;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharTwo   = 8'h32;
  localparam logic [7:0] CharThree = 8'h33;
  localparam logic [7:0] CharFive  = 8'h35;
  localparam logic [7:0] CharNine  = 8'h39;

endpackage

// File: hw/rtl/swc_if.sv
// swc_in_if / swc_out_if: valid-ready channels of the settable wall clock
// no dependencies
interface swc_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [63:0] text_low;
  logic [31:0] text_high;

  modport source (output valid, output command, output text_low, output text_high,
                  input ready);
  modport sink (input valid, input command, input text_low, input text_high,
                output ready);
endinterface

interface swc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] hour_tens;
  logic [3:0] hour_ones;
  logic [2:0] minute_tens;
  logic [3:0] minute_ones;
  logic [2:0] second_tens;
  logic [3:0] second_ones;

  modport source (output valid, output hour_tens, output hour_ones, output minute_tens,
                  output minute_ones, output second_tens, output second_ones,
                  input ready);
  modport sink (input valid, input hour_tens, input hour_ones, input minute_tens,
                input minute_ones, input second_tens, input second_ones,
                output ready);
endinterface

// File: hw/rtl/settable_wall_clock.sv
// settable_wall_clock: 24-hour clock driven by ticks and text commands
// depends on swc_pkg, swc_if, swc_decode, swc_queue, swc_exec
//
// in_i carries one transaction per tick (command = 0) or text command
// (command = 1, characters in text_low and text_high). Reset "WR", set
// " S hh:mm:ss" and stop " T" commands are decoded in the front end; bad set
// commands and unknown text are dropped there. Other transactions go through
// a small command queue (QueueDepth entries) to the back end, which keeps the
// time as bcd hour, minute and second counters.
// out_o carries the six time digits after each tick taken while running;
// commands and ticks while stopped give no output.
// A tick is written into the queue when accepted, waits there until the back
// end executes it, and its result goes to the result register that drives
// out_o. Throughput: one transaction per cycle, set by the single result
// register; when out_o stalls, ticks wait in the queue and in_i drops ready
// once the queue is full. Commands pass a stalled tick only in order, never
// ahead of it.
// Reset: the clock stops at 00:00:00 and the queue and output are empty.
module settable_wall_clock import swc_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  swc_in_if.sink    in_i,
  swc_out_if.source out_o
);

  logic push_valid, push_ready, pop_valid, pop_ready;
  cmd_t push_cmd, pop_cmd;

  swc_decode u_decode (
    .in_i         (in_i),
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .push_cmd_o   (push_cmd)
  );

  swc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  swc_exec u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_cmd_i   (pop_cmd),
    .out_o       (out_o)
  );

endmodule

// File: hw/rtl/swc_decode.sv
// swc_decode: front end, classifies ticks and text commands into queue entries
// depends on swc_pkg and swc_in_if
module swc_decode import swc_pkg::*; (
  swc_in_if.sink     in_i,
  input  logic       push_ready_i,
  output logic       push_valid_o,
  output cmd_t       push_cmd_o
);

  logic [7:0] c [1:12];
  logic       is_reset, is_set_form, is_stop, set_ok;
  logic       digits_ok, ranges_ok;

  always_comb begin
    for (int p = 1; p <= 8; p++) begin
      c[p] = in_i.text_low[8*(p-1) +: 8];
    end
    for (int p = 9; p <= 12; p++) begin
      c[p] = in_i.text_high[8*(p-9) +: 8];
    end
  end

  function automatic logic is_digit(input logic [7:0] ch);
    return (ch >= CharZero) && (ch <= CharNine);
  endfunction

  assign is_reset    = (c[1] == CharW) && (c[2] == CharR) && (c[3] == CharNul);
  assign is_set_form = (c[2] == CharS) && (c[3] == CharSpace) && (c[12] == CharNul);
  assign is_stop     = (c[2] == CharT) && (c[3] == CharNul);

  assign digits_ok = is_digit(c[4]) && is_digit(c[5]) && is_digit(c[7]) &&
                     is_digit(c[8]) && is_digit(c[10]) && is_digit(c[11]);
  // hour up to 23, minute and second tens up to 5
  assign ranges_ok = ((c[4] < CharTwo) || ((c[4] == CharTwo) && (c[5] <= CharThree))) &&
                     (c[7] <= CharFive) && (c[10] <= CharFive);
  assign set_ok    = (c[6] == CharColon) && (c[9] == CharColon) && digits_ok && ranges_ok;

  always_comb begin
    push_cmd_o.op               = OP_TICK;
    push_cmd_o.load.hour_tens   = c[4][1:0];
    push_cmd_o.load.hour_ones   = c[5][3:0];
    push_cmd_o.load.minute_tens = c[7][2:0];
    push_cmd_o.load.minute_ones = c[8][3:0];
    push_cmd_o.load.second_tens = c[10][2:0];
    push_cmd_o.load.second_ones = c[11][3:0];
    push_valid_o                = 1'b0;
    if (!in_i.command) begin
      push_valid_o = in_i.valid;
    end else if (is_reset) begin
      push_cmd_o.op = OP_RESET;
      push_valid_o  = in_i.valid;
    end else if (is_set_form) begin
      // a bad set command is dropped here
      push_cmd_o.op = OP_SET;
      push_valid_o  = in_i.valid && set_ok;
    end else if (is_stop) begin
      push_cmd_o.op = OP_STOP;
      push_valid_o  = in_i.valid;
    end
  end

  // unknown commands are taken and dropped, but only when the queue could take them
  assign in_i.ready = push_ready_i;

endmodule

// File: hw/rtl/swc_queue.sv
// swc_queue: short fifo of decoded commands between front and back
// depends on swc_pkg
module swc_queue import swc_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_cmd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(Depth))
    else $error("queue fill count above depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with unequal pointers");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (push && !pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("push did not raise fill count");

endmodule

// File: hw/rtl/swc_exec.sv
// swc_exec: back end, holds the time counters and the result register
// depends on swc_pkg and swc_out_if
module swc_exec import swc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pop_valid_i,
  output logic       pop_ready_o,
  input  cmd_t       pop_cmd_i,
  swc_out_if.source  out_o
);

  time_t time_q, time_d, time_next;
  time_t res_q;
  logic  running_q, running_d;
  logic  out_valid_q, out_valid_d;
  logic  pop, emit, out_free;
  logic  sec_wrap, min_wrap, hour_wrap;

  // bcd increment by one second, wrapping at one day
  assign sec_wrap  = (time_q.second_tens == 3'd5) && (time_q.second_ones == 4'd9);
  assign min_wrap  = (time_q.minute_tens == 3'd5) && (time_q.minute_ones == 4'd9);
  assign hour_wrap = (time_q.hour_tens == 2'd2) && (time_q.hour_ones == 4'd3);

  always_comb begin
    time_next = time_q;
    if (time_q.second_ones == 4'd9) begin
      time_next.second_ones = '0;
      time_next.second_tens = sec_wrap ? '0 : time_q.second_tens + 1'b1;
    end else begin
      time_next.second_ones = time_q.second_ones + 1'b1;
    end
    if (sec_wrap) begin
      if (time_q.minute_ones == 4'd9) begin
        time_next.minute_ones = '0;
        time_next.minute_tens = min_wrap ? '0 : time_q.minute_tens + 1'b1;
      end else begin
        time_next.minute_ones = time_q.minute_ones + 1'b1;
      end
      if (min_wrap) begin
        if (hour_wrap) begin
          time_next.hour_tens = '0;
          time_next.hour_ones = '0;
        end else if (time_q.hour_ones == 4'd9) begin
          time_next.hour_ones = '0;
          time_next.hour_tens = time_q.hour_tens + 1'b1;
        end else begin
          time_next.hour_ones = time_q.hour_ones + 1'b1;
        end
      end
    end
  end

  assign out_free    = !out_valid_q || out_o.ready;
  // only a tick that produces a result waits for the result register
  assign pop_ready_o = (pop_cmd_i.op != OP_TICK) || !running_q || out_free;
  assign pop         = pop_valid_i && pop_ready_o;
  assign emit        = pop && (pop_cmd_i.op == OP_TICK) && running_q;

  always_comb begin
    time_d    = time_q;
    running_d = running_q;
    if (pop) begin
      case (pop_cmd_i.op)
        OP_TICK: begin
          if (running_q) begin
            time_d = time_next;
          end
        end
        OP_RESET: begin
          time_d    = '0;
          running_d = 1'b1;
        end
        OP_SET: begin
          time_d    = pop_cmd_i.load;
          running_d = 1'b1;
        end
        OP_STOP: begin
          running_d = 1'b0;
        end
        default: begin
          time_d = time_q;
        end
      endcase
    end
    out_valid_d = emit || (out_valid_q && !out_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q      <= '0;
      running_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      time_q      <= time_d;
      running_q   <= running_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= time_next;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.hour_tens   = res_q.hour_tens;
  assign out_o.hour_ones   = res_q.hour_ones;
  assign out_o.minute_tens = res_q.minute_tens;
  assign out_o.minute_ones = res_q.minute_ones;
  assign out_o.second_tens = res_q.second_tens;
  assign out_o.second_ones = res_q.second_ones;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (pop && pop_cmd_i.op == OP_STOP) |=> !running_q)
    else $error("clock still running after stop");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (pop && pop_cmd_i.op == OP_RESET) |=> (running_q && time_q == '0))
    else $error("reset command did not clear and start the clock");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   emit |=> (out_valid_q && res_q == time_q))
    else $error("result does not match the advanced time");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && !out_o.ready) |-> !emit)
    else $error("result register overwritten while stalled");

endmodule
